FILE: rtl/byte_ring_fifo_overwrite_top_defines.svh
// Assertion macros shared by the checker of the byte ring FIFO.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BYTE_RING_FIFO_OVERWRITE_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_OVERWRITE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRFO_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brfo check failed: same-cycle property");

// Next-cycle implication, checked outside reset.
`define BRFO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brfo check failed: next-cycle property");

`endif

FILE: rtl/brfo_pkg.sv
// Shared types and constants of the byte ring FIFO.
// No dependencies; used by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package brfo_pkg;

    localparam int STATUS_W = 3;
    localparam int DATA_W   = 8;
    localparam int CFG_W    = 9;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_READ_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRITTEN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_WRITTEN = 3'd4;

    // Request types.
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } brfo_cmd_t;

endpackage

FILE: rtl/brfo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module brfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/brfo_ctrl.sv
// Controller state machine of the byte ring FIFO.
// Depends on brfo_pkg for the command struct.
`timescale 1ns / 1ps

module brfo_ctrl
    import brfo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output brfo_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } brfo_state_t;

    brfo_state_t state_reg;
    brfo_state_t state_next;

    // Next-state logic: one item walks through execute and respond.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:  state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands and handshake outputs.
    assign busy        = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && start;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.respond = (state_reg == S_DONE);
    assign done        = cmd.respond;

endmodule

FILE: rtl/brfo_dp.sv
// Datapath of the byte ring FIFO: pointers, flags, length and byte memory.
// Depends on brfo_pkg and instantiates brfo_ram.
`timescale 1ns / 1ps

module brfo_dp
    import brfo_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  brfo_cmd_t           cmd,
    input  logic                req_type,
    input  logic [DATA_W-1:0]   write_data,
    input  logic                overwrite_enable,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   read_data,
    output logic                data_lost
);

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CMP_W     = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;
    localparam int RESET_LEN = (DEPTH < 256) ? DEPTH : 256;
    localparam logic [PTR_W-1:0] LAST_RST = PTR_W'(RESET_LEN - 1);

    // Captured request.
    logic              req_type_reg;
    logic [DATA_W-1:0] write_data_reg;
    logic              ovr_reg;

    // Ring state.
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic                full_reg, full_next;
    logic                lost_reg, lost_next;
    logic [PTR_W-1:0]    last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [PTR_W-1:0]  rd_adv;
    logic [PTR_W-1:0]  wr_adv;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;
    logic [CMP_W-1:0]  len_wide;
    logic [CMP_W-1:0]  len_clamped;

    // Request capture at acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg   <= req_type;
            write_data_reg <= write_data;
            ovr_reg        <= overwrite_enable;
        end
    end

    // Pointer advance with wrap at the programmed length.
    assign rd_adv = (rd_ptr_reg == last_reg) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_adv = (wr_ptr_reg == last_reg) ? '0 : wr_ptr_reg + 1'b1;

    // Length clamp: zero acts as one, values past the memory act as its depth.
    always_comb
    begin
        len_wide = CMP_W'(cfg_wdata);
        if (len_wide == '0)
        begin
            len_clamped = CMP_W'(1);
        end
        else if (len_wide > CMP_W'(DEPTH))
        begin
            len_clamped = CMP_W'(DEPTH);
        end
        else
        begin
            len_clamped = len_wide;
        end
    end

    // Request execution and configuration writes.
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        full_next   = full_reg;
        lost_next   = lost_reg;
        last_next   = last_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        if (cfg_we)
        begin
            // A new length empties the ring but keeps the lost flag.
            last_next   = PTR_W'(len_clamped - 1'b1);
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            full_next   = 1'b0;
        end
        else if (cmd.exec)
        begin
            if (req_type_reg == REQ_READ)
            begin
                if ((rd_ptr_reg == wr_ptr_reg) && !full_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ram_re      = 1'b1;
                    rd_ptr_next = rd_adv;
                    full_next   = 1'b0;
                    status_next = ST_READ_OK;
                end
            end
            else if (!full_reg)
            begin
                ram_we      = 1'b1;
                wr_ptr_next = wr_adv;
                full_next   = (wr_adv == rd_ptr_reg);
                status_next = ST_WRITTEN;
            end
            else if (ovr_reg)
            begin
                // Replace the oldest byte; the ring stays full.
                ram_we      = 1'b1;
                wr_ptr_next = wr_adv;
                rd_ptr_next = wr_adv;
                lost_next   = 1'b1;
                status_next = ST_OVERWRITTEN;
            end
            else
            begin
                status_next = ST_NOT_WRITTEN;
            end
        end
    end

    // Ring state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            full_reg   <= 1'b0;
            lost_reg   <= 1'b0;
            last_reg   <= LAST_RST;
            status_reg <= ST_EMPTY;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            full_reg   <= full_next;
            lost_reg   <= lost_next;
            last_reg   <= last_next;
            status_reg <= status_next;
        end
    end

    // Byte memory.
    brfo_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (write_data_reg),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Result fields; read data is zero unless the read succeeded.
    assign status    = status_reg;
    assign read_data = (status_reg == ST_READ_OK) ? ram_rdata : '0;
    assign data_lost = lost_reg;

endmodule

FILE: rtl/byte_ring_fifo_overwrite_top.sv
// Top level of the byte ring FIFO with overwrite of the oldest byte.
// Depends on brfo_pkg; instantiates brfo_ctrl and brfo_dp.
//
// Channel   Handshake         Fields
// request   start / busy      req_type, write_data, overwrite_enable
// result    done (strobe)     status, read_data, data_lost
// config    cfg_we            cfg_wdata (buffer_length)
//
// An item accepted at an edge moves through the execute state and then the done state,
// where its done strobe is shown; busy then drops and the next item can be accepted.
// The done state follows the registered read of the byte RAM issued in the execute step.
// Reset clears pointers, flags and the controller; the RAM needs no clearing pass.
// The result cannot be stalled: done is high for exactly one cycle.
`timescale 1ns / 1ps

module byte_ring_fifo_overwrite_top
    import brfo_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [DATA_W-1:0]   write_data,
    input  logic                overwrite_enable,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   read_data,
    output logic                data_lost,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    brfo_cmd_t cmd;

    // Sequencing of one item.
    brfo_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Ring state and storage.
    brfo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .req_type         (req_type),
        .write_data       (write_data),
        .overwrite_enable (overwrite_enable),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .status           (status),
        .read_data        (read_data),
        .data_lost        (data_lost)
    );

endmodule

FILE: rtl/brfo_checker.sv
// Port-level checker of the byte ring FIFO, bound to the top level.
// Depends on brfo_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "byte_ring_fifo_overwrite_top_defines.svh"

module brfo_checker
    import brfo_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [DATA_W-1:0]   read_data,
    input logic                data_lost
);

    // An accepted item keeps the block busy in the next cycle.
    `BRFO_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // A result only appears while an item is in flight.
    `BRFO_ASSERT_NOW(a_done_busy, done, busy)

    // The strobe lasts one cycle.
    `BRFO_ASSERT_NEXT(a_done_pulse, done, !done)

    // Read data is zero unless the read succeeded.
    `BRFO_ASSERT_NOW(a_rdata_zero, done && (status != ST_READ_OK), read_data == '0)

    // The lost flag never clears once set.
    `BRFO_ASSERT_NEXT(a_lost_sticky, data_lost, data_lost)

endmodule

bind byte_ring_fifo_overwrite_top brfo_checker u_brfo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .read_data (read_data),
    .data_lost (data_lost)
);

FILE: dv/tb_byte_ring_fifo_overwrite_top.sv
// Testbench for the byte ring FIFO with overwrite of the oldest byte.
// Depends on brfo_pkg and byte_ring_fifo_overwrite_top; a shadow ring predicts every result.
`timescale 1ns / 1ps

module tb_byte_ring_fifo_overwrite_top;
    import brfo_pkg::*;

    localparam int RING_DEPTH  = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   read_data;
        logic                data_lost;
    } ring_resp_t;

    // Block ports; the inputs are known from time zero.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                req_type = REQ_READ;
    logic [DATA_W-1:0]   write_data = '0;
    logic                overwrite_enable = 1'b0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic                data_lost;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    // Shadow copy of the ring and its length register.
    logic [DATA_W-1:0] shadow_mem [0:RING_DEPTH-1];
    int unsigned       shadow_rd_ptr = 0;
    int unsigned       shadow_wr_ptr = 0;
    bit                shadow_full = 1'b0;
    bit                shadow_lost = 1'b0;
    logic [CFG_W-1:0]  shadow_len = 9'd256;

    ring_resp_t expected_responses[$];
    bit         idle_enable = 1'b0;
    int         error_count = 0;
    int         items_sent = 0;
    int         length_writes = 0;
    int         status_seen [0:7];
    int         cycle_count = 0;

    byte_ring_fifo_overwrite_top #(
        .DEPTH(RING_DEPTH)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .req_type         (req_type),
        .write_data       (write_data),
        .overwrite_enable (overwrite_enable),
        .done             (done),
        .status           (status),
        .read_data        (read_data),
        .data_lost        (data_lost),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Length in use: zero acts as one, anything above the depth acts as the depth.
    function automatic int unsigned slots_in_use();
        if (shadow_len == 0)
            return 1;
        if (shadow_len > RING_DEPTH)
            return RING_DEPTH;
        return shadow_len;
    endfunction

    function automatic int unsigned next_slot(input int unsigned p);
        return (p + 1 >= slots_in_use()) ? 0 : p + 1;
    endfunction

    // Applies one request to the shadow ring and returns the result it gives.
    function automatic ring_resp_t predict_ring_response(input logic rt,
                                                         input logic [DATA_W-1:0] wd,
                                                         input logic ow);
        ring_resp_t  r;
        int unsigned rp;
        int unsigned wp;
        rp = shadow_rd_ptr % RING_DEPTH;
        wp = shadow_wr_ptr % RING_DEPTH;
        r.read_data = '0;
        if (rt == REQ_READ)
        begin
            if (rp == wp && !shadow_full)
                r.status = ST_EMPTY;
            else
            begin
                r.read_data   = shadow_mem[rp];
                shadow_rd_ptr = next_slot(rp);
                shadow_full   = 1'b0;
                r.status      = ST_READ_OK;
            end
        end
        else if (!shadow_full)
        begin
            shadow_mem[wp] = wd;
            shadow_wr_ptr  = next_slot(wp);
            if (shadow_wr_ptr == rp)
                shadow_full = 1'b1;
            r.status = ST_WRITTEN;
        end
        else if (ow)
        begin
            shadow_mem[wp] = wd;
            shadow_wr_ptr  = next_slot(wp);
            shadow_rd_ptr  = shadow_wr_ptr;
            shadow_lost    = 1'b1;
            r.status       = ST_OVERWRITTEN;
        end
        else
            r.status = ST_NOT_WRITTEN;
        r.data_lost = shadow_lost;
        return r;
    endfunction

    // Compares each result strobe with the oldest expected result.
    always @(posedge clk)
    begin : response_check
        ring_resp_t exp_r;
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("Result with no item waiting: status %0d read_data 0x%02h data_lost %0b",
                       status, read_data, data_lost);
                error_count++;
            end
            else
            begin
                exp_r = expected_responses.pop_front();
                status_seen[status]++;
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, status);
                    error_count++;
                end
                if (read_data !== exp_r.read_data)
                begin
                    $error("read_data: expected 0x%02h, actual 0x%02h",
                           exp_r.read_data, read_data);
                    error_count++;
                end
                if (data_lost !== exp_r.data_lost)
                begin
                    $error("data_lost: expected %0b, actual %0b", exp_r.data_lost, data_lost);
                    error_count++;
                end
            end
        end
    end

    // Presents one item and returns at the edge that accepts it.
    task automatic send_item(input logic rt, input logic [DATA_W-1:0] wd, input logic ow);
        req_type         <= rt;
        write_data       <= wd;
        overwrite_enable <= ow;
        start            <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_responses.push_back(predict_ring_response(rt, wd, ow));
        items_sent++;
        // Random sender gap after the accepted item.
        if (idle_enable && ($urandom_range(0, 3) == 0))
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic hold_until_drained();
        start <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    // Writes the length register while the block is idle; the ring empties.
    task automatic write_length(input logic [CFG_W-1:0] value);
        hold_until_drained();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        shadow_len    = value;
        shadow_rd_ptr = 0;
        shadow_wr_ptr = 0;
        shadow_full   = 1'b0;
        length_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Empty reads at reset length, byte extremes, and overwrite enable on a non-full ring.
    task automatic test_reset_state_reads();
        send_item(REQ_READ, 8'hFF, 1'b1);
        send_item(REQ_WRITE, 8'h00, 1'b0);
        send_item(REQ_WRITE, 8'hFF, 1'b0);
        send_item(REQ_WRITE, 8'h5A, 1'b1);
        send_item(REQ_READ, 8'h00, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
    endtask

    // A one-slot ring: full after one write, refused write, overwrite sets the lost flag.
    task automatic test_single_slot();
        write_length(9'd1);
        send_item(REQ_WRITE, 8'hA5, 1'b0);
        send_item(REQ_WRITE, 8'h3C, 1'b0);
        send_item(REQ_WRITE, 8'hC3, 1'b1);
        send_item(REQ_READ, 8'h00, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
    endtask

    // Out-of-range lengths: zero acts as one slot, the largest code as the full depth.
    task automatic test_length_clamp();
        write_length(9'd0);
        send_item(REQ_WRITE, 8'h11, 1'b0);
        send_item(REQ_WRITE, 8'h22, 1'b0);
        write_length(9'h1FF);
        send_item(REQ_WRITE, 8'h33, 1'b0);
        send_item(REQ_WRITE, 8'h44, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
    endtask

    // A length write empties the ring but keeps the lost flag.
    task automatic test_length_write_empties();
        write_length(9'd3);
        send_item(REQ_WRITE, 8'h81, 1'b0);
        send_item(REQ_WRITE, 8'h7E, 1'b0);
        write_length(9'd3);
        send_item(REQ_READ, 8'h00, 1'b0);
        send_item(REQ_WRITE, 8'h01, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
    endtask

    // Fill the ring at full depth, overwrite across the wrap, then drain it.
    task automatic test_full_ring_wrap();
        write_length(9'd256);
        idle_enable = 1'b1;
        for (int i = 0; i < RING_DEPTH; i++)
            send_item(REQ_WRITE, DATA_W'($urandom_range(0, 255)), 1'b0);
        send_item(REQ_WRITE, 8'hEE, 1'b0);
        for (int i = 0; i < 3; i++)
            send_item(REQ_WRITE, DATA_W'($urandom_range(0, 255)), 1'b1);
        for (int i = 0; i < RING_DEPTH + 1; i++)
            send_item(REQ_READ, DATA_W'($urandom_range(0, 255)), 1'(($urandom_range(0, 1))));
    endtask

    // Random bursts of fills, drains and mixed traffic over a range of lengths.
    task automatic test_random_traffic();
        int unsigned len;
        int unsigned write_pct;
        int unsigned burst_left;
        logic        rt;
        write_pct  = 50;
        burst_left = 0;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: len = 1;
                1: len = 2;
                2: len = 3;
                3: len = $urandom_range(4, 8);
                4: len = $urandom_range(9, 32);
                5: len = $urandom_range(2, 16);
                6: len = 256;
                7: len = $urandom_range(33, 255);
                8: len = 2;
                default: len = $urandom_range(3, 12);
            endcase
            write_length(CFG_W'(len));
            // The last phases and one early phase run without sender gaps.
            idle_enable = (ph < 8) && (ph != 3);
            for (int n = 0; n < 8; n++)
            begin
                if (burst_left == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: write_pct = 85;
                        1: write_pct = 15;
                        default: write_pct = 50;
                    endcase
                    burst_left = $urandom_range(4, (2 * len + 4 > 40) ? 40 : 2 * len + 4);
                end
                burst_left--;
                rt = ($urandom_range(0, 99) < write_pct) ? REQ_WRITE : REQ_READ;
                send_item(rt, DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                if (ph == 5 && n == 4)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            shadow_mem[i] = '0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state_reads();
        test_single_slot();
        test_length_clamp();
        test_length_write_empties();
        test_full_ring_wrap();
        test_random_traffic();

        hold_until_drained();
        repeat (8)
            @(posedge clk);
        $display("Summary: %0d items over %0d length writes; read ok %0d, empty %0d,",
                 items_sent, length_writes, status_seen[ST_READ_OK], status_seen[ST_EMPTY]);
        $display("written %0d, overwritten %0d, refused %0d.", status_seen[ST_WRITTEN],
                 status_seen[ST_OVERWRITTEN], status_seen[ST_NOT_WRITTEN]);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
